>>> rtl/mftt_pkg.sv
// ----------------------------------------------------------------------------
// mftt_pkg
// Shared types and constants of the motor feedback turn tracker: the item
// passed from the front part to the back part, register indexes and the
// wrap thresholds of the turn count update.
// ----------------------------------------------------------------------------
package mftt_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_ID_BASE     = 2'd0;
    localparam logic [1:0] REG_BUS_OFFSET  = 2'd1;
    localparam logic [1:0] REG_ENC_PERIOD  = 2'd2;

    // reset values of the configuration registers
    localparam logic [10:0] ID_BASE_RST    = 11'd513;
    localparam logic [4:0]  BUS_OFFSET_RST = 5'd11;
    localparam logic [15:0] ENC_PERIOD_RST = 16'd8192;

    // encoder wrap thresholds
    localparam logic [15:0] WRAP_HIGH = 16'd6000;
    localparam logic [15:0] WRAP_LOW  = 16'd3000;

    // widths
    localparam int SLOT_NUM_W = 8;   // holds any slot number up to 256 slots
    localparam int SUM_W      = 13;  // signed slot computation
    localparam int CFG_W      = 16;  // widest configuration register
    localparam int COUNT_W    = 32;
    localparam int POS_W      = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // classified item, front to back
    typedef struct packed {
        logic                   bad;
        logic [SLOT_NUM_W-1:0]  slot_num;
        logic [15:0]            encoder;
        logic signed [15:0]     speed;
        logic signed [15:0]     current;
        logic [7:0]             temperature;
    } mftt_item_t;

endpackage

>>> rtl/mftt_front.sv
// ----------------------------------------------------------------------------
// mftt_front
// Front part: maps a frame to a motor slot, flags slots outside the table
// and unpacks encoder, speed, current and temperature from the payload.
// ----------------------------------------------------------------------------
module mftt_front #(
    parameter int SLOTS = 32
) (
    input  logic                      bus,
    input  logic [10:0]               frame_id,
    input  logic [63:0]               payload,
    input  logic [10:0]               id_base,
    input  logic [4:0]                bus_offset,
    output mftt_pkg::mftt_item_t      item
);

    logic [mftt_pkg::SUM_W-1:0] slot_sum;
    logic [mftt_pkg::SUM_W-1:0] offset_add;
    logic                       slot_neg;
    logic                       slot_high;

    // signed slot number, with the second bus offset where it applies
    assign offset_add = bus ? {{(mftt_pkg::SUM_W-5){1'b0}}, bus_offset}
                            : {mftt_pkg::SUM_W{1'b0}};
    assign slot_sum   = {2'b00, frame_id} - {2'b00, id_base} + offset_add;

    // range check against the table size
    assign slot_neg  = slot_sum[mftt_pkg::SUM_W-1];
    assign slot_high = slot_sum[mftt_pkg::SUM_W-2:0] >= (mftt_pkg::SUM_W-1)'(SLOTS);

    // classified item
    always_comb begin
        item             = '0;
        item.bad         = slot_neg | slot_high;
        item.slot_num    = slot_sum[mftt_pkg::SLOT_NUM_W-1:0];
        item.encoder     = payload[63:48];
        item.speed       = $signed(payload[47:32]);
        item.current     = $signed(payload[31:16]);
        item.temperature = payload[15:8];
    end

endmodule

>>> rtl/mftt_queue.sv
// ----------------------------------------------------------------------------
// mftt_queue
// Short first-in first-out queue of classified items between the front and
// the back part, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mftt_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  mftt_pkg::mftt_item_t   push_item,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output mftt_pkg::mftt_item_t   head_item
);

    mftt_pkg::mftt_item_t             entry_reg [mftt_pkg::QUEUE_DEPTH];
    logic [mftt_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [mftt_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [mftt_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [mftt_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [mftt_pkg::QPTR_W:0]        count_reg;
    logic [mftt_pkg::QPTR_W:0]        count_next;

    assign full       = count_reg == (mftt_pkg::QPTR_W+1)'(mftt_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/mftt_back.sv
// ----------------------------------------------------------------------------
// mftt_back
// Back part: reads the slot state from the per-slot memory, applies the
// wrap-corrected turn count update, writes the state back for slots in range
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module mftt_back #(
    parameter int SLOTS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        head_valid,
    input  mftt_pkg::mftt_item_t        head_item,
    output logic                        pop,
    input  logic [15:0]                 enc_period,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [4:0]                  m_slot,
    output logic                        m_slot_bad,
    output logic [15:0]                 m_encoder,
    output logic signed [15:0]          m_speed,
    output logic signed [15:0]          m_current,
    output logic [7:0]                  m_temperature,
    output logic signed [31:0]          m_turn_count
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int STATE_W = mftt_pkg::POS_W + mftt_pkg::COUNT_W;

    // per-slot state memory and its written flags
    logic [STATE_W-1:0]             state_mem [SLOTS];
    logic [SLOTS-1:0]               written_reg;

    // read stage
    logic                           b_valid_reg;
    mftt_pkg::mftt_item_t           b_item_reg;
    logic [STATE_W-1:0]             rd_data_reg;
    logic                           rd_hit_reg;

    // last write, forwarded over the read that overlaps it
    logic                           last_valid_reg;
    logic [SLOT_W-1:0]              last_idx_reg;
    logic [STATE_W-1:0]             last_state_reg;

    // output register
    logic                           out_valid_reg;
    mftt_pkg::mftt_item_t           out_item_reg;
    logic [mftt_pkg::COUNT_W-1:0]   out_count_reg;

    logic                           b_fire;
    logic                           b_write;
    logic [SLOT_W-1:0]              head_idx;
    logic [SLOT_W-1:0]              b_idx;
    logic [STATE_W-1:0]             cur_state;
    logic [mftt_pkg::POS_W-1:0]     prev_pos;
    logic [mftt_pkg::COUNT_W-1:0]   prev_count;
    logic                           wrap_fwd;
    logic                           wrap_bwd;
    logic [mftt_pkg::COUNT_W-1:0]   plain_delta;
    logic [mftt_pkg::COUNT_W-1:0]   period_ext;
    logic [mftt_pkg::COUNT_W-1:0]   delta;
    logic [mftt_pkg::COUNT_W-1:0]   count_next;

    assign head_idx = head_item.slot_num[SLOT_W-1:0];
    assign b_idx    = b_item_reg.slot_num[SLOT_W-1:0];

    // stage handshakes
    assign b_fire  = b_valid_reg && (!out_valid_reg || m_ready);
    assign b_write = b_fire && !b_item_reg.bad;
    assign pop     = head_valid && (!b_valid_reg || b_fire);

    // current slot state: forwarded, stored, or zero if never written
    always_comb begin
        priority if (last_valid_reg && last_idx_reg == b_idx) begin
            cur_state = last_state_reg;
        end else if (rd_hit_reg) begin
            cur_state = rd_data_reg;
        end else begin
            cur_state = '0;
        end
    end

    assign prev_pos   = cur_state[STATE_W-1:mftt_pkg::COUNT_W];
    assign prev_count = cur_state[mftt_pkg::COUNT_W-1:0];

    // wrap-corrected turn count update
    assign wrap_fwd    = (prev_pos > mftt_pkg::WRAP_HIGH) &&
                         (b_item_reg.encoder < mftt_pkg::WRAP_LOW);
    assign wrap_bwd    = (prev_pos < mftt_pkg::WRAP_LOW) &&
                         (b_item_reg.encoder > mftt_pkg::WRAP_HIGH);
    assign period_ext  = {{(mftt_pkg::COUNT_W-16){1'b0}}, enc_period};
    assign plain_delta = {{(mftt_pkg::COUNT_W-16){1'b0}}, b_item_reg.encoder}
                       - {{(mftt_pkg::COUNT_W-mftt_pkg::POS_W){1'b0}}, prev_pos};

    always_comb begin
        priority if (wrap_fwd) begin
            delta = plain_delta + period_ext;
        end else if (wrap_bwd) begin
            delta = plain_delta - period_ext;
        end else begin
            delta = plain_delta;
        end
    end

    assign count_next = prev_count + delta;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
            written_reg    <= '0;
        end else begin
            if (pop) begin
                b_valid_reg <= 1'b1;
            end else if (b_fire) begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (b_write) begin
                last_valid_reg      <= 1'b1;
                written_reg[b_idx]  <= 1'b1;
            end
        end
    end

    // read stage payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            b_item_reg  <= head_item;
            rd_data_reg <= state_mem[head_idx];
            rd_hit_reg  <= written_reg[head_idx];
        end
    end

    // state write-back and forwarding copy
    always_ff @(posedge aclk) begin
        if (b_write) begin
            state_mem[b_idx] <= {b_item_reg.encoder, count_next};
            last_idx_reg     <= b_idx;
            last_state_reg   <= {b_item_reg.encoder, count_next};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (b_fire) begin
            out_item_reg  <= b_item_reg;
            out_count_reg <= b_item_reg.bad ? '0 : count_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_slot        = out_item_reg.bad ? 5'd0 : out_item_reg.slot_num[4:0];
    assign m_slot_bad    = out_item_reg.bad;
    assign m_encoder     = out_item_reg.encoder;
    assign m_speed       = out_item_reg.speed;
    assign m_current     = out_item_reg.current;
    assign m_temperature = out_item_reg.temperature;
    assign m_turn_count  = $signed(out_count_reg);

endmodule

>>> rtl/motor_feedback_turn_tracker.sv
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker
// Tracks the multi-turn encoder count of each motor slot from received
// motor feedback frames, unwrapping encoder roll-over per slot.
//
//   channel   ports          handshake        payload
//   input     s_*            s_valid/s_ready  bus, frame_id, payload
//   result    m_*            m_valid/m_ready  slot, slot_bad, encoder, speed,
//                                             current, temperature, turn_count
//   config    cfg_*          cfg_wr_en        cfg_index, cfg_wdata
//
// One item per cycle sustained while m_ready stays high; an accepted item
// passes the queue, the state memory read stage and the output register.
// Slot state read-modify-write runs in one back stage; the write that
// overlaps the next read is forwarded from a copy register.
// Reset clears the per-slot written flags, so every slot reads as zero.
// A stalled result holds the back part; the queue keeps the front accepting
// until it is full.
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker #(
    parameter int SLOTS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_bus,
    input  logic [10:0]         s_frame_id,
    input  logic [63:0]         s_payload,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [4:0]          m_slot,
    output logic                m_slot_bad,
    output logic [15:0]         m_encoder,
    output logic signed [15:0]  m_speed,
    output logic signed [15:0]  m_current,
    output logic [7:0]          m_temperature,
    output logic signed [31:0]  m_turn_count,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);

    logic [10:0]            id_base_reg;
    logic [4:0]             bus_offset_reg;
    logic [15:0]            enc_period_reg;

    mftt_pkg::mftt_item_t   front_item;
    mftt_pkg::mftt_item_t   head_item;
    logic                   queue_full;
    logic                   head_valid;
    logic                   pop;
    logic                   push;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_base_reg    <= mftt_pkg::ID_BASE_RST;
            bus_offset_reg <= mftt_pkg::BUS_OFFSET_RST;
            enc_period_reg <= mftt_pkg::ENC_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mftt_pkg::REG_ID_BASE:    id_base_reg    <= cfg_wdata[10:0];
                mftt_pkg::REG_BUS_OFFSET: bus_offset_reg <= cfg_wdata[4:0];
                mftt_pkg::REG_ENC_PERIOD: enc_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input handshake
    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    mftt_front #(
        .SLOTS      (SLOTS)
    ) u_front (
        .bus        (s_bus),
        .frame_id   (s_frame_id),
        .payload    (s_payload),
        .id_base    (id_base_reg),
        .bus_offset (bus_offset_reg),
        .item       (front_item)
    );

    mftt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mftt_back #(
        .SLOTS         (SLOTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .enc_period    (enc_period_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_slot_bad    (m_slot_bad),
        .m_encoder     (m_encoder),
        .m_speed       (m_speed),
        .m_current     (m_current),
        .m_temperature (m_temperature),
        .m_turn_count  (m_turn_count)
    );

endmodule
